// ===== design/rt_pkg.sv =====
`default_nettype none

package rt_pkg;

    // input kinds carried in s_tuser
    localparam logic [1:0] OP_SEND = 2'd0;
    localparam logic [1:0] OP_ACK  = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    // register indexes, decoded from paddr[2]
    localparam logic REG_DELAY = 1'b0;
    localparam logic REG_LIMIT = 1'b1;

    localparam int APB_ADDR_W = 3;

    localparam logic [15:0] DELAY_RESET = 16'd60;
    localparam logic [7:0]  LIMIT_RESET = 8'd10;
    localparam logic [7:0]  COUNT_MAX   = 8'hFF;

    typedef enum logic [2:0] {
        ST_FIRST    = 3'd0,
        ST_RESEND   = 3'd1,
        ST_LOST     = 3'd2,
        ST_FULL     = 3'd3,
        ST_ACK_HIT  = 3'd4,
        ST_ACK_MISS = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        CMP_EQ,
        CMP_GT,
        CMP_LT
    } cmp_mode_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FREE,
        S_ACK,
        S_AGE,
        S_SORT,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic [31:0] seq;
        logic [47:0] dest;
        logic [7:0]  handle;
        logic [31:0] sent_ms;
        logic [7:0]  tx_count;
    } entry_t;

endpackage

`default_nettype wire

// ===== design/rt_ram.sv =====
`default_nettype none

module rt_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

// ===== design/rt_cmp.sv =====
`default_nettype none

// shared subtract and compare unit: diff = a - b, flag by mode
module rt_cmp (
    input  wire rt_pkg::cmp_mode_t mode,
    input  wire logic [31:0]       a,
    input  wire logic [31:0]       b,
    input  wire logic [31:0]       c,
    output logic      [31:0]       diff,
    output logic                   flag
);

    always_comb begin
        diff = a - b;
        unique case (mode)
            rt_pkg::CMP_EQ: flag = (diff == 32'd0);
            rt_pkg::CMP_GT: flag = (diff > c);
            rt_pkg::CMP_LT: flag = (diff < c);
            default:        flag = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

// ===== design/rt_cfg.sv =====
`default_nettype none

module rt_cfg (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [rt_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready,
    output logic      [15:0]                   resend_delay,
    output logic      [7:0]                    resend_limit
);

    logic [15:0] delay_reg;
    logic [15:0] delay_next;
    logic [7:0]  limit_reg;
    logic [7:0]  limit_next;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb begin
        delay_next = delay_reg;
        limit_next = limit_reg;
        if (wr_en) begin
            unique case (paddr[2])
                rt_pkg::REG_DELAY: delay_next = pwdata[15:0];
                rt_pkg::REG_LIMIT: limit_next = pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            rt_pkg::REG_DELAY: prdata = {16'd0, delay_reg};
            rt_pkg::REG_LIMIT: prdata = {24'd0, limit_reg};
            default:           prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg <= rt_pkg::DELAY_RESET;
            limit_reg <= rt_pkg::LIMIT_RESET;
        end else begin
            delay_reg <= delay_next;
            limit_reg <= limit_next;
        end
    end

    assign resend_delay = delay_reg;
    assign resend_limit = limit_reg;

endmodule

`default_nettype wire

// ===== design/retransmit_table.sv =====
// untracked send goes from idle to the emit state and then into the output register; tracked send
// first searches for a free slot (the search walks the valid bits one a cycle); ack runs one ram sweep
// tick: the ageing sweep runs first, then one ordering sweep per resent entry,
// each resend being one ordering sweep through the single read port of the entry ram
// one word in flight at a time; s_tready high only between words
// reset: clears valid bits, sequence counter and output valid, delay 60, limit 10
`default_nettype none

module retransmit_table #(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // s_tdata: now_ms[31:0], dest_addr[79:32], payload_handle[87:80],
    //          tracked[88], ack_index[120:89], zero pad[127:121]
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [127:0]                  s_tdata,
    // s_tuser: op[1:0]
    input  wire logic [1:0]                    s_tuser,
    // m_tdata: seq_index[31:0], dest_out[79:32], handle_out[87:80]
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [87:0]                   m_tdata,
    // m_tuser: status[2:0]
    output logic      [2:0]                    m_tuser,
    output logic                               m_tlast,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [rt_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);
    localparam logic [CNT_W-1:0] LAST_C  = CNT_W'(TABLE_DEPTH - 1);
    localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

    logic [15:0] resend_delay;
    logic [7:0]  resend_limit;

    rt_pkg::state_t state_reg, state_next;

    logic [31:0]            next_seq_reg, next_seq_next;
    logic [TABLE_DEPTH-1:0] entry_valid_reg, entry_valid_next;
    logic [TABLE_DEPTH-1:0] due_reg, due_next;
    logic [TABLE_DEPTH-1:0] lost_reg, lost_next;
    logic [CNT_W-1:0]       addr_reg, addr_next;
    logic                   pv_reg, pv_next;
    logic [IDX_W-1:0]       pidx_reg, pidx_next;
    logic                   hit_reg, hit_next;
    logic                   found_reg, found_next;
    logic [CNT_W-1:0]       rem_reg, rem_next;
    logic [31:0]            best_key_reg, best_key_next;
    logic [IDX_W-1:0]       best_idx_reg, best_idx_next;
    logic [31:0]            now_reg, now_next;

    logic [31:0]     res_seq_reg, res_seq_next;
    logic [47:0]     res_dest_reg, res_dest_next;
    logic [7:0]      res_handle_reg, res_handle_next;
    rt_pkg::status_t res_status_reg, res_status_next;
    logic            res_last_reg, res_last_next;

    logic        m_tvalid_reg, m_tvalid_next;
    logic [87:0] m_tdata_reg, m_tdata_next;
    logic [2:0]  m_tuser_reg, m_tuser_next;
    logic        m_tlast_reg, m_tlast_next;

    logic                                  ram_we;
    logic [IDX_W-1:0]                      ram_waddr;
    rt_pkg::entry_t                        ram_wdata;
    logic [$bits(rt_pkg::entry_t)-1:0]     ram_rdata;
    rt_pkg::entry_t                        rd_word;

    rt_pkg::cmp_mode_t cmp_mode;
    logic [31:0]       cmp_a, cmp_b, cmp_c, cmp_diff;
    logic              cmp_flag;

    logic        accept;
    logic [1:0]  in_op;
    logic [31:0] in_now;
    logic [47:0] in_dest;
    logic [7:0]  in_handle;
    logic        in_tracked;
    logic [31:0] in_ack;

    logic [IDX_W-1:0] idx_cur;
    logic             issue_done;
    logic             scan_done;
    logic             out_free;
    logic             free_hit;
    logic             free_end;
    logic             pv_valid;
    logic             pv_due;
    logic [7:0]       new_count;
    logic             new_lost;

    rt_cfg u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .resend_delay (resend_delay),
        .resend_limit (resend_limit)
    );

    rt_ram #(
        .WIDTH ($bits(rt_pkg::entry_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_cur),
        .rdata (ram_rdata)
    );

    rt_cmp u_cmp (
        .mode (cmp_mode),
        .a    (cmp_a),
        .b    (cmp_b),
        .c    (cmp_c),
        .diff (cmp_diff),
        .flag (cmp_flag)
    );

    assign rd_word    = ram_rdata;
    assign in_op      = s_tuser;
    assign in_now     = s_tdata[31:0];
    assign in_dest    = s_tdata[79:32];
    assign in_handle  = s_tdata[87:80];
    assign in_tracked = s_tdata[88];
    assign in_ack     = s_tdata[120:89];

    assign s_tready   = (state_reg == rt_pkg::S_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign idx_cur    = addr_reg[IDX_W-1:0];
    assign issue_done = (addr_reg == DEPTH_C);
    assign scan_done  = issue_done && !pv_reg;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign free_hit   = !entry_valid_reg[idx_cur];
    assign free_end   = (addr_reg == LAST_C);
    assign pv_valid   = entry_valid_reg[pidx_reg];
    assign pv_due     = due_reg[pidx_reg];
    assign new_count  = (rd_word.tx_count == rt_pkg::COUNT_MAX) ? rt_pkg::COUNT_MAX
                                                                : rd_word.tx_count + 8'd1;
    assign new_lost   = (new_count >= resend_limit);

    // operand routing for the shared compare unit
    always_comb begin
        cmp_mode = rt_pkg::CMP_EQ;
        cmp_a    = rd_word.seq;
        cmp_b    = res_seq_reg;
        cmp_c    = 32'd0;
        unique case (state_reg)
            rt_pkg::S_AGE: begin
                cmp_mode = rt_pkg::CMP_GT;
                cmp_a    = now_reg;
                cmp_b    = rd_word.sent_ms;
                cmp_c    = {16'd0, resend_delay};
            end
            rt_pkg::S_SORT: begin
                // issue order key relative to the next index
                cmp_mode = rt_pkg::CMP_LT;
                cmp_a    = rd_word.seq;
                cmp_b    = next_seq_reg;
                cmp_c    = best_key_reg;
            end
            default: ;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rt_pkg::S_IDLE: begin
                if (accept) begin
                    priority if (in_op == rt_pkg::OP_SEND) begin
                        state_next = in_tracked ? rt_pkg::S_FREE : rt_pkg::S_EMIT;
                    end else if (in_op == rt_pkg::OP_ACK) begin
                        state_next = rt_pkg::S_ACK;
                    end else if (in_op == rt_pkg::OP_TICK) begin
                        state_next = rt_pkg::S_AGE;
                    end else begin
                        state_next = rt_pkg::S_IDLE;
                    end
                end
            end
            rt_pkg::S_FREE: begin
                if (free_hit || free_end) begin
                    state_next = rt_pkg::S_EMIT;
                end
            end
            rt_pkg::S_ACK: begin
                if (scan_done) begin
                    state_next = rt_pkg::S_EMIT;
                end
            end
            rt_pkg::S_AGE: begin
                if (scan_done) begin
                    state_next = (rem_reg == '0) ? rt_pkg::S_IDLE : rt_pkg::S_SORT;
                end
            end
            rt_pkg::S_SORT: begin
                if (scan_done) begin
                    state_next = rt_pkg::S_EMIT;
                end
            end
            rt_pkg::S_EMIT: begin
                if (out_free) begin
                    state_next = res_last_reg ? rt_pkg::S_IDLE : rt_pkg::S_SORT;
                end
            end
            default: state_next = rt_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        next_seq_next    = next_seq_reg;
        entry_valid_next = entry_valid_reg;
        due_next         = due_reg;
        lost_next        = lost_reg;
        addr_next        = addr_reg;
        pv_next          = pv_reg;
        pidx_next        = pidx_reg;
        hit_next         = hit_reg;
        found_next       = found_reg;
        rem_next         = rem_reg;
        best_key_next    = best_key_reg;
        best_idx_next    = best_idx_reg;
        now_next         = now_reg;
        res_seq_next     = res_seq_reg;
        res_dest_next    = res_dest_reg;
        res_handle_next  = res_handle_reg;
        res_status_next  = res_status_reg;
        res_last_next    = res_last_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_tdata_next     = m_tdata_reg;
        m_tuser_next     = m_tuser_reg;
        m_tlast_next     = m_tlast_reg;
        ram_we           = 1'b0;
        ram_waddr        = pidx_reg;
        ram_wdata        = rd_word;

        // read pipeline shared by the ram sweeps
        if (state_reg == rt_pkg::S_ACK || state_reg == rt_pkg::S_AGE ||
            state_reg == rt_pkg::S_SORT) begin
            addr_next = issue_done ? addr_reg : addr_reg + ONE_C;
            pv_next   = !issue_done;
            pidx_next = idx_cur;
        end

        unique case (state_reg)
            rt_pkg::S_IDLE: begin
                if (accept) begin
                    now_next        = in_now;
                    addr_next       = '0;
                    pv_next         = 1'b0;
                    hit_next        = 1'b0;
                    found_next      = 1'b0;
                    rem_next        = '0;
                    res_status_next = rt_pkg::ST_FIRST;
                    res_last_next   = 1'b1;
                    if (in_op == rt_pkg::OP_ACK) begin
                        res_seq_next    = in_ack;
                        res_dest_next   = '0;
                        res_handle_next = '0;
                    end else begin
                        res_seq_next    = next_seq_reg;
                        res_dest_next   = in_dest;
                        res_handle_next = in_handle;
                    end
                    if (in_op == rt_pkg::OP_SEND) begin
                        next_seq_next = next_seq_reg + 32'd1;
                    end
                end
            end
            rt_pkg::S_FREE: begin
                priority if (free_hit) begin
                    ram_we    = 1'b1;
                    ram_waddr = idx_cur;
                    ram_wdata = rt_pkg::entry_t'{
                        seq:      res_seq_reg,
                        dest:     res_dest_reg,
                        handle:   res_handle_reg,
                        sent_ms:  now_reg,
                        tx_count: 8'd1
                    };
                    entry_valid_next[idx_cur] = 1'b1;
                end else if (free_end) begin
                    res_status_next = rt_pkg::ST_FULL;
                end else begin
                    addr_next = addr_reg + ONE_C;
                end
            end
            rt_pkg::S_ACK: begin
                if (pv_reg && pv_valid && cmp_flag) begin
                    entry_valid_next[pidx_reg] = 1'b0;
                    hit_next = 1'b1;
                    // first match in slot order supplies the destination
                    if (!hit_reg) begin
                        res_dest_next   = rd_word.dest;
                        res_handle_next = rd_word.handle;
                    end
                end
                if (scan_done) begin
                    res_status_next = hit_reg ? rt_pkg::ST_ACK_HIT : rt_pkg::ST_ACK_MISS;
                end
            end
            rt_pkg::S_AGE: begin
                if (pv_reg && pv_valid && cmp_flag) begin
                    due_next[pidx_reg]  = 1'b1;
                    lost_next[pidx_reg] = new_lost;
                    if (new_lost) begin
                        entry_valid_next[pidx_reg] = 1'b0;
                    end
                    ram_we            = 1'b1;
                    ram_wdata.sent_ms  = now_reg;
                    ram_wdata.tx_count = new_count;
                    rem_next          = rem_reg + ONE_C;
                end
                if (scan_done) begin
                    addr_next  = '0;
                    pv_next    = 1'b0;
                    found_next = 1'b0;
                end
            end
            rt_pkg::S_SORT: begin
                // lowest key wins, ties keep the lower slot
                if (pv_reg && pv_due && (!found_reg || cmp_flag)) begin
                    found_next      = 1'b1;
                    best_key_next   = cmp_diff;
                    best_idx_next   = pidx_reg;
                    res_seq_next    = rd_word.seq;
                    res_dest_next   = rd_word.dest;
                    res_handle_next = rd_word.handle;
                end
                if (scan_done) begin
                    res_status_next = lost_reg[best_idx_reg] ? rt_pkg::ST_LOST
                                                             : rt_pkg::ST_RESEND;
                    res_last_next   = (rem_reg == ONE_C);
                    due_next[best_idx_reg] = 1'b0;
                    rem_next        = rem_reg - ONE_C;
                end
            end
            rt_pkg::S_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {res_handle_reg, res_dest_reg, res_seq_reg};
                    m_tuser_next  = res_status_reg;
                    m_tlast_next  = res_last_reg;
                    if (!res_last_reg) begin
                        addr_next  = '0;
                        pv_next    = 1'b0;
                        found_next = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= rt_pkg::S_IDLE;
            next_seq_reg    <= '0;
            entry_valid_reg <= '0;
            due_reg         <= '0;
            addr_reg        <= '0;
            pv_reg          <= 1'b0;
            hit_reg         <= 1'b0;
            found_reg       <= 1'b0;
            rem_reg         <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            next_seq_reg    <= next_seq_next;
            entry_valid_reg <= entry_valid_next;
            due_reg         <= due_next;
            addr_reg        <= addr_next;
            pv_reg          <= pv_next;
            hit_reg         <= hit_next;
            found_reg       <= found_next;
            rem_reg         <= rem_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        lost_reg       <= lost_next;
        pidx_reg       <= pidx_next;
        best_key_reg   <= best_key_next;
        best_idx_reg   <= best_idx_next;
        now_reg        <= now_next;
        res_seq_reg    <= res_seq_next;
        res_dest_reg   <= res_dest_next;
        res_handle_reg <= res_handle_next;
        res_status_reg <= res_status_next;
        res_last_reg   <= res_last_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
        m_tlast_reg    <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // every send word takes exactly one index
    a_seq_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && in_op == rt_pkg::OP_SEND) |=> (next_seq_reg == $past(next_seq_reg) + 32'd1))
        else $error("sequence index did not advance on send");

    // an ordering sweep always finds a pending resend
    a_sort_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rt_pkg::S_SORT && scan_done) |-> found_reg)
        else $error("ordering sweep ended without a candidate");

    // all pending resends are delivered before the next word
    a_due_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rt_pkg::S_IDLE) |-> (due_reg == '0 && rem_reg == '0))
        else $error("pending resends left over at idle");

endmodule

`default_nettype wire
